>>> src/tvec_pkg.sv
// Shared types, constants and helpers for the triangle tangent pipeline.
`default_nettype none
package tvec_pkg;

	localparam int unsigned PosW   = 32;
	localparam int unsigned TexW   = 48;
	localparam int unsigned UvW    = 24;
	localparam int unsigned EdgeW  = 33;
	localparam int unsigned DeltaW = 25;
	localparam int unsigned DetW   = 51;
	localparam int unsigned NumW   = 59;
	localparam int unsigned FloorW = 41;
	localparam int unsigned FracSh = 12;
	localparam int unsigned QBits  = 32;
	localparam int unsigned Lanes  = 3;
	localparam int unsigned Lat    = 6 + QBits;

	localparam logic [FloorW-1:0] FloorReset = 41'd1099512;
	localparam logic [PosW-1:0]   PosMax     = 32'h7FFF_FFFF;
	localparam logic [PosW-1:0]   NegMax     = 32'h8000_0000;

	typedef struct packed {
		logic signed [DetW-1:0] det;
		logic [Lanes-1:0][NumW-1:0] num;
	} front_t;

	typedef struct packed {
		logic             neg;
		logic             sat;
		logic [DetW-1:0]  rem;
		logic [QBits-1:0] low;
		logic [QBits-1:0] quo;
	} lane_t;

	typedef struct packed {
		logic [DetW-1:0] dmag;
		lane_t [Lanes-1:0] lane;
	} div_t;

	typedef struct packed {
		logic            clip;
		logic [PosW-1:0] val;
	} res_t;

	function automatic res_t finish(input lane_t l);
		res_t r;
		r.clip = 1'b0;
		r.val  = l.quo;
		if (l.sat) begin
			r.clip = 1'b1;
			r.val  = l.neg ? NegMax : PosMax;
		end else if (l.neg) begin
			if (l.quo > NegMax) begin
				r.clip = 1'b1;
				r.val  = NegMax;
			end else begin
				r.val = PosW'(~l.quo + 1'b1);
			end
		end else if (l.quo[QBits-1]) begin
			r.clip = 1'b1;
			r.val  = PosMax;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/tvec_front.sv
// Front stages: edges and UV deltas, products, then det and numerators.
`default_nettype none
module tvec_front import tvec_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_vld,
	input  wire logic [2:0][2:0][PosW-1:0] pos,
	input  wire logic [2:0][TexW-1:0]   tex,
	output logic                        out_vld,
	output front_t                      out
);

	logic vld_s1, vld_s2;
	logic signed [2:0][EdgeW-1:0] q1_s1, q2_s1;
	logic signed [DeltaW-1:0] du1_s1, dv1_s1, du2_s1, dv2_s1;
	logic signed [DetW-2:0] pd1_s2, pd2_s2;
	logic signed [2:0][NumW-2:0] pn1_s2, pn2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			out_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			q1_s1[i] <= EdgeW'($signed(pos[1][i])) - EdgeW'($signed(pos[0][i]));
			q2_s1[i] <= EdgeW'($signed(pos[2][i])) - EdgeW'($signed(pos[0][i]));
		end
		du1_s1 <= DeltaW'($signed(tex[1][UvW-1:0])) - DeltaW'($signed(tex[0][UvW-1:0]));
		dv1_s1 <= DeltaW'($signed(tex[1][TexW-1:UvW])) - DeltaW'($signed(tex[0][TexW-1:UvW]));
		du2_s1 <= DeltaW'($signed(tex[2][UvW-1:0])) - DeltaW'($signed(tex[0][UvW-1:0]));
		dv2_s1 <= DeltaW'($signed(tex[2][TexW-1:UvW])) - DeltaW'($signed(tex[0][TexW-1:UvW]));
	end

	always_ff @(posedge clk) begin
		pd1_s2 <= (DetW-1)'(du1_s1) * (DetW-1)'(dv2_s1);
		pd2_s2 <= (DetW-1)'(du2_s1) * (DetW-1)'(dv1_s1);
		for (int i = 0; i < 3; i++) begin
			pn1_s2[i] <= (NumW-1)'(dv2_s1) * (NumW-1)'($signed(q1_s1[i]));
			pn2_s2[i] <= (NumW-1)'(dv1_s1) * (NumW-1)'($signed(q2_s1[i]));
		end
	end

	always_ff @(posedge clk) begin
		out.det <= DetW'(pd1_s2) - DetW'(pd2_s2);
		for (int i = 0; i < 3; i++) begin
			out.num[i] <= NumW'($signed(pn1_s2[i])) - NumW'($signed(pn2_s2[i]));
		end
	end

endmodule
`default_nettype wire

>>> src/tvec_prep.sv
// Divider setup: magnitudes, det floor, sign and overflow check.
`default_nettype none
module tvec_prep import tvec_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [FloorW-1:0] det_floor,
	input  wire logic              in_vld,
	input  wire front_t            in,
	output logic                   out_vld,
	output div_t                   out
);

	logic vld_s4;
	logic [DetW-1:0] dmag_s4;
	logic dneg_s4;
	logic [Lanes-1:0][NumW-1:0] nmag_s4;
	logic [Lanes-1:0] nneg_s4;

	logic [DetW-1:0]   det_abs, fl;
	logic              det_low;

	always_comb begin
		det_abs = in.det[DetW-1] ? DetW'(-in.det) : DetW'(in.det);
		fl      = (det_floor == '0) ? DetW'(1) : DetW'(det_floor);
		det_low = det_abs < fl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s4  <= in_vld;
			out_vld <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		dmag_s4 <= det_low ? fl : det_abs;
		dneg_s4 <= det_low ? (in.det <= 0) : in.det[DetW-1];
		for (int i = 0; i < Lanes; i++) begin
			nneg_s4[i] <= in.num[i][NumW-1];
			nmag_s4[i] <= in.num[i][NumW-1] ? NumW'(~in.num[i] + 1'b1) : in.num[i];
		end
	end

	always_ff @(posedge clk) begin
		out.dmag <= dmag_s4;
		for (int i = 0; i < Lanes; i++) begin
			out.lane[i].neg <= nneg_s4[i] ^ dneg_s4;
			out.lane[i].sat <= (DetW+FracSh)'(nmag_s4[i]) >= {dmag_s4, FracSh'(0)};
			out.lane[i].rem <= DetW'(nmag_s4[i][NumW-1:FracSh]);
			out.lane[i].low <= {nmag_s4[i][FracSh-1:0], (QBits-FracSh)'(0)};
			out.lane[i].quo <= '0;
		end
	end

endmodule
`default_nettype wire

>>> src/tvec_div.sv
// Restoring divider, one quotient bit per stage, three lanes sharing the divisor.
`default_nettype none
module tvec_div import tvec_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_vld,
	input  wire div_t in,
	output logic      out_vld,
	output div_t      out
);

	logic [QBits:1] vld_s;
	div_t           pipe_s [1:QBits];

	assign out_vld = vld_s[QBits];
	assign out     = pipe_s[QBits];

	for (genvar k = 0; k < QBits; k++) begin : g_stage
		div_t          cur, nxt;
		logic          cur_vld;
		logic [DetW:0] t;

		if (k == 0) begin : g_head
			assign cur     = in;
			assign cur_vld = in_vld;
		end else begin : g_body
			assign cur     = pipe_s[k];
			assign cur_vld = vld_s[k];
		end

		always_comb begin
			nxt = cur;
			t   = '0;
			for (int i = 0; i < Lanes; i++) begin
				t = {cur.lane[i].rem, cur.lane[i].low[QBits-1]};
				if (t >= {1'b0, cur.dmag}) begin
					nxt.lane[i].rem = DetW'(t - {1'b0, cur.dmag});
					nxt.lane[i].quo = {cur.lane[i].quo[QBits-2:0], 1'b1};
				end else begin
					nxt.lane[i].rem = DetW'(t);
					nxt.lane[i].quo = {cur.lane[i].quo[QBits-2:0], 1'b0};
				end
				nxt.lane[i].low = {cur.lane[i].low[QBits-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			pipe_s[k+1] <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> src/triangle_tangent_vector.sv
// Top level: per-triangle tangent from positions and UVs, fully pipelined.
//
//  channel  | control         | data
//  ---------+-----------------+-------------------------------------------
//  input    | start, busy     | p0_x..p2_z, tex0..tex2
//  result   | done            | tan_x, tan_y, tan_z, clipped
//  config   | cfg_we          | cfg_wdata (det_floor)
//
// One triangle per cycle; each result passes through these stages in order:
// 3 front stages, 2 setup stages, 32 divider stages, 1 output stage.
// The divider pipeline sets the latency, one quotient bit per stage.
// Reset clears the valid bits and loads det_floor with about 1e-6.
// busy stays low; results cannot be held off, so nothing ever stalls.
`default_nettype none
module triangle_tangent_vector import tvec_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [FloorW-1:0] cfg_wdata,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [PosW-1:0]   p0_x,
	input  wire logic [PosW-1:0]   p0_y,
	input  wire logic [PosW-1:0]   p0_z,
	input  wire logic [PosW-1:0]   p1_x,
	input  wire logic [PosW-1:0]   p1_y,
	input  wire logic [PosW-1:0]   p1_z,
	input  wire logic [PosW-1:0]   p2_x,
	input  wire logic [PosW-1:0]   p2_y,
	input  wire logic [PosW-1:0]   p2_z,
	input  wire logic [TexW-1:0]   tex0,
	input  wire logic [TexW-1:0]   tex1,
	input  wire logic [TexW-1:0]   tex2,
	output logic                   done,
	output logic [PosW-1:0]        tan_x,
	output logic [PosW-1:0]        tan_y,
	output logic [PosW-1:0]        tan_z,
	output logic                   clipped
);

	logic [FloorW-1:0] det_floor_q;
	logic [2:0][2:0][PosW-1:0] pos;
	logic [2:0][TexW-1:0] tex;
	logic   front_vld, prep_vld, div_vld;
	front_t front_res;
	div_t   prep_res, div_res;
	res_t   rx, ry, rz;

	assign busy = 1'b0;
	assign pos  = {{p2_z, p2_y, p2_x}, {p1_z, p1_y, p1_x}, {p0_z, p0_y, p0_x}};
	assign tex  = {tex2, tex1, tex0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_floor_q <= FloorReset;
		end else if (cfg_we) begin
			det_floor_q <= cfg_wdata;
		end
	end

	tvec_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.pos     (pos),
		.tex     (tex),
		.out_vld (front_vld),
		.out     (front_res)
	);

	tvec_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.det_floor (det_floor_q),
		.in_vld    (front_vld),
		.in        (front_res),
		.out_vld   (prep_vld),
		.out       (prep_res)
	);

	tvec_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (prep_vld),
		.in      (prep_res),
		.out_vld (div_vld),
		.out     (div_res)
	);

	always_comb begin
		rx = finish(div_res.lane[0]);
		ry = finish(div_res.lane[1]);
		rz = finish(div_res.lane[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		tan_x   <= rx.val;
		tan_y   <= ry.val;
		tan_z   <= rz.val;
		clipped <= rx.clip | ry.clip | rz.clip;
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##Lat done)
		else $error("result missing after fixed latency");
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start, Lat) |-> !done)
		else $error("result without a transfer");
	a_clip_ext: assert property (@(posedge clk) disable iff (!arst_n)
		done && clipped |-> tan_x == PosMax || tan_x == NegMax
			|| tan_y == PosMax || tan_y == NegMax
			|| tan_z == PosMax || tan_z == NegMax)
		else $error("clipped set without a saturated component");
`endif

endmodule
`default_nettype wire

>>> dv/tangent_checker.sv
// Checker for the triangle tangent block: predicts each tangent and compares results.
module tangent_checker import tvec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [FloorW-1:0] cfg_wdata,
	input  logic              start,
	input  logic              busy,
	input  logic [PosW-1:0]   p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
	input  logic [TexW-1:0]   tex0, tex1, tex2,
	input  logic              done,
	input  logic [PosW-1:0]   tan_x, tan_y, tan_z,
	input  logic              clipped,
	output int                fail_count,
	output int                pending
);
	typedef struct {
		logic [PosW-1:0] t [3];
		logic            clip;
	} tangent_t;

	tangent_t         expected_tangents [$];
	logic [FloorW-1:0] floor_reg;

	function automatic logic [PosW-1:0] div_sat(input longint num, input bit det_neg,
			input longint unsigned dmag, inout bit clip);
		bit neg;
		longint unsigned nmag, q, r;
		longint val;
		if (num == 0)
			return '0;
		neg = (num < 0) != det_neg;
		nmag = (num < 0) ? -num : num;
		if (nmag >= (dmag << 12)) begin
			clip = 1;
			return neg ? NegMax : PosMax;
		end
		q = nmag / dmag;
		r = nmag % dmag;
		for (int i = 0; i < 20; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= dmag) begin
				r -= dmag;
				q |= 1;
			end
		end
		val = neg ? -longint'(q) : longint'(q);
		if (val > 64'sd2147483647) begin
			clip = 1;
			val = 64'sd2147483647;
		end else if (val < -64'sd2147483648) begin
			clip = 1;
			val = -64'sd2147483648;
		end
		return val[31:0];
	endfunction

	function automatic tangent_t predict_tangent();
		tangent_t res;
		longint q1 [3], q2 [3];
		longint du1, dv1, du2, dv2, det, num;
		longint unsigned dmag, fl;
		bit det_neg, clip;
		q1[0] = longint'(signed'(p1_x)) - longint'(signed'(p0_x));
		q1[1] = longint'(signed'(p1_y)) - longint'(signed'(p0_y));
		q1[2] = longint'(signed'(p1_z)) - longint'(signed'(p0_z));
		q2[0] = longint'(signed'(p2_x)) - longint'(signed'(p0_x));
		q2[1] = longint'(signed'(p2_y)) - longint'(signed'(p0_y));
		q2[2] = longint'(signed'(p2_z)) - longint'(signed'(p0_z));
		du1 = longint'(signed'(tex1[23:0])) - longint'(signed'(tex0[23:0]));
		dv1 = longint'(signed'(tex1[47:24])) - longint'(signed'(tex0[47:24]));
		du2 = longint'(signed'(tex2[23:0])) - longint'(signed'(tex0[23:0]));
		dv2 = longint'(signed'(tex2[47:24])) - longint'(signed'(tex0[47:24]));
		det = du1 * dv2 - du2 * dv1;
		det_neg = det < 0;
		dmag = det_neg ? -det : det;
		fl = (floor_reg == 0) ? 1 : longint'(floor_reg);
		if (dmag < fl) begin
			det_neg = !(det > 0);
			dmag = fl;
		end
		clip = 0;
		for (int i = 0; i < 3; i++) begin
			num = dv2 * q1[i] - dv1 * q2[i];
			res.t[i] = div_sat(num, det_neg, dmag, clip);
		end
		res.clip = clip;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tangent_t exp_t;
		if (!arst_n) begin
			floor_reg = FloorReset;
			fail_count = 0;
			expected_tangents.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (expected_tangents.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected transfer: tan %h %h %h clip %b",
							tan_x, tan_y, tan_z, clipped);
				end else begin
					exp_t = expected_tangents.pop_front();
					if (tan_x !== exp_t.t[0] || tan_y !== exp_t.t[1] ||
							tan_z !== exp_t.t[2] || clipped !== exp_t.clip) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp %h %h %h %b got %h %h %h %b",
								exp_t.t[0], exp_t.t[1], exp_t.t[2], exp_t.clip,
								tan_x, tan_y, tan_z, clipped);
					end
				end
			end
			if (start && !busy)
				expected_tangents.push_back(predict_tangent());
			if (cfg_we)
				floor_reg = cfg_wdata;
			pending = expected_tangents.size();
		end
	end
endmodule

>>> dv/testbench.sv
// Testbench top: drives triangles and det_floor settings, reports the verdict.
module testbench;
	import tvec_pkg::*;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              cfg_we = 0;
	logic [FloorW-1:0] cfg_wdata = '0;
	logic              start = 0;
	logic              busy, done, clipped;
	logic [PosW-1:0]   p0_x = 0, p0_y = 0, p0_z = 0, p1_x = 0, p1_y = 0, p1_z = 0;
	logic [PosW-1:0]   p2_x = 0, p2_y = 0, p2_z = 0;
	logic [TexW-1:0]   tex0 = 0, tex1 = 0, tex2 = 0;
	logic [PosW-1:0]   tan_x, tan_y, tan_z;
	int                fail_count, pending;
	int                cycles = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	triangle_tangent_vector dut (.*);

	tangent_checker chk (.*);

	function automatic logic [31:0] pick_pos(input int mode);
		case (mode)
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h3_0000)
				: -$urandom_range(0, 32'h3_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [23:0] pick_uv(input int mode);
		case (mode)
			0: return 24'h7F_FFFF;
			1: return 24'h80_0000;
			2: return 24'($urandom_range(0, 24'h10_0000));
			3: return 24'($urandom_range(0, 3));
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_triangle(input logic [31:0] pos [9], input logic [TexW-1:0] t [3]);
		{p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z} =
			{pos[0], pos[1], pos[2], pos[3], pos[4], pos[5], pos[6], pos[7], pos[8]};
		{tex0, tex1, tex2} = {t[0], t[1], t[2]};
		start = 1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic random_triangle(input bit gaps);
		logic [31:0]     pos [9];
		logic [TexW-1:0] t [3];
		int              pm, um, gap;
		pm = $urandom_range(0, 5);
		um = $urandom_range(0, 6);
		foreach (pos[i])
			pos[i] = pick_pos(pm > 3 ? 2 : (pm == 3 ? $urandom_range(0, 3) : 3));
		foreach (t[i])
			t[i] = {pick_uv(um > 4 ? 2 : (um == 4 ? $urandom_range(0, 4) : um)),
				pick_uv(um > 4 ? 2 : (um == 4 ? $urandom_range(0, 4) : um))};
		if (um == 4 && $urandom_range(0, 1))
			t[2] = t[1];
		send_triangle(pos, t);
		gap = gaps ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			start = 0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_floor(input logic [FloorW-1:0] v);
		start = 0;
		while (pending != 0) @(negedge clk);
		repeat (45) @(negedge clk);
		cfg_we = 1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 0;
	endtask

	initial begin
		logic [31:0]     pos [9];
		logic [TexW-1:0] t [3];
		logic [FloorW-1:0] floors [5];
		floors = '{41'd0, 41'h100_0000_0000, 41'd1, 41'h1FF_FFFF_FFFF, 41'd1099512};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: extremes, zero det, degenerate UVs, saturation
		for (int d = 0; d < 16; d++) begin
			foreach (pos[i])
				pos[i] = (d[0] ^ (i < 3)) ? 32'h7FFF_FFFF : 32'h8000_0000;
			if (d < 4) foreach (pos[i]) pos[i] = 0;
			case (d % 4)
				0: t = '{48'h0, 48'h0, 48'h0};
				1: t = '{48'h0, 48'h00_0000_10_0000, 48'h10_0000_00_0000};
				2: t = '{48'h80_0000_80_0000, 48'h7F_FFFF_80_0000, 48'h80_0000_7F_FFFF};
				default: t = '{48'h7F_FFFF_7F_FFFF, 48'h80_0000_7F_FFFF,
					48'h7F_FFFF_80_0000};
			endcase
			if (d >= 8 && d < 12) begin
				pos = '{0, 0, 0, 32'h1_0000, 32'hFFFF_0000, 0, 0, 32'h2_0000, 32'hFFFE_0000};
				t = '{48'h0, 48'h000000_000001, 48'h000001_000000};
				if (d == 9) t[1] = 48'hFFFFFF_000001;
			end
			send_triangle(pos, t);
		end
		foreach (floors[f]) begin
			write_floor(floors[f]);
			for (int n = 0; n < 160; n++)
				random_triangle((n / 40) % 2 == 0);
		end
		start = 0;
		while (pending != 0) @(negedge clk);
		repeat (45) @(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
